### rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types, constants and helpers of the scalar kalman filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

	localparam int MulW  = 38;
	localparam int DivNW = 64;
	localparam int DivDW = 40;
	localparam int CfgIdxW = 3;

	localparam logic [31:0] ResetTransition  = 32'h1000_0000;
	localparam logic [31:0] ResetObservation = 32'h1000_0000;
	localparam logic [31:0] ResetProcNoise   = 32'd2684;
	localparam logic [31:0] ResetMeasNoise   = 32'd2684355;
	localparam logic [31:0] ResetInitCov     = 32'h1000_0000;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_TRANSITION  = 3'd0,
		CFG_OBSERVATION = 3'd1,
		CFG_PROC_NOISE  = 3'd2,
		CFG_MEAS_NOISE  = 3'd3,
		CFG_INIT_COV    = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XP,
		ST_T1,
		ST_PP,
		ST_D1,
		ST_DEN,
		ST_DIV,
		ST_KI,
		ST_KH,
		ST_PN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic            start;
		logic [MulW-1:0] a;
		logic [MulW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic             start;
		logic [DivNW-1:0] num;
		logic [DivDW-1:0] den;
	} div_req_t;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		mag32 = v[31] ? (32'd0 - v) : v;
	endfunction

	function automatic logic [31:0] sat_s50(input logic signed [49:0] v);
		if (v > 50'sd2147483647)
			sat_s50 = 32'h7fff_ffff;
		else if (v < -50'sd2147483648)
			sat_s50 = 32'h8000_0000;
		else
			sat_s50 = v[31:0];
	endfunction

endpackage

`default_nettype wire

### rtl/scalar_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_core
// One-dimensional fixed-point kalman filter, predict then update per item.
//
//   channel  signals                              direction
//   in       in_valid/in_ready, measurement       into core
//   out      out_valid/out_ready, estimate,       out of core
//            gain, covariance
//   cfg      cfg_valid/cfg_ready, cfg_index,      into core
//            cfg_data
//
// an item passes through eight bit-serial multiplies in sequence and the
// restoring divider, which overlaps a ninth multiply, each followed by a
// handoff, then the output register is loaded; when 1 - k*h is not positive
// the last multiply is skipped.
// one item is in flight at a time; in_ready and cfg_ready are high only when idle.
// a finished result waits in the output register while out_ready is low.
// reset loads the register defaults, estimate 0 and covariance 1.0.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_core
	import skf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [31:0]        measurement,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [31:0]             estimate,
	output logic [31:0]             gain,
	output logic [31:0]             covariance,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [31:0]        cfg_data
);

	state_t state_q, state_d;

	logic [31:0] a_q, h_q, qn_q, rn_q;
	logic [31:0] x_q, p_q;
	logic [31:0] z_q, xp_q, pp_q, k_q, xn_q, pn_q;
	logic [63:0] num_q;
	logic        den_zero_q;
	logic        innov_neg_q;
	logic        out_valid_q;
	logic [31:0] est_q, gain_q, cov_q;

	mul_req_t           mreq;
	div_req_t           dreq;
	logic               mul_done, div_done;
	logic [2*MulW-1:0]  mul_prod;
	logic [DivNW-1:0]   div_quo;

	logic [31:0]        amag, hmag;
	logic [47:0]        mhi;
	logic [49:0]        mhi_x;
	logic [48:0]        pp_sum;
	logic [31:0]        pp_w;
	logic [49:0]        den_sum;
	logic signed [49:0] xp_ext;
	logic signed [49:0] sm_xh, innov, innov_abs;
	logic [31:0]        k_w;
	logic signed [49:0] sm_ki, xn_sum;
	logic signed [49:0] sm_kh, om;
	logic               load_out;

	skf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	skf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign amag   = mag32(a_q);
	assign hmag   = mag32(h_q);
	assign mhi    = mul_prod[2*MulW-1:28];
	assign mhi_x  = {2'b00, mhi};
	assign xp_ext = {{18{xp_q[31]}}, xp_q};

	assign pp_sum  = {1'b0, mhi} + {17'd0, qn_q};
	assign pp_w    = (pp_sum[48:32] != 17'd0) ? 32'hffff_ffff : pp_sum[31:0];
	assign den_sum = mhi_x + {18'd0, rn_q};

	assign sm_xh     = (xp_q[31] ^ h_q[31]) ? -$signed(mhi_x) : $signed(mhi_x);
	assign innov     = $signed({{18{z_q[31]}}, z_q}) - sm_xh;
	assign innov_abs = innov[49] ? -innov : innov;

	always_comb begin
		if (den_zero_q)
			k_w = 32'd0;
		else if (h_q[31])
			k_w = (div_quo > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - div_quo[31:0]);
		else
			k_w = (div_quo > 64'h7fff_ffff) ? 32'h7fff_ffff : div_quo[31:0];
	end

	assign sm_ki  = (k_q[31] ^ innov_neg_q) ? -$signed(mhi_x) : $signed(mhi_x);
	assign xn_sum = xp_ext + sm_ki;
	assign sm_kh  = (k_q[31] ^ h_q[31]) ? -$signed(mhi_x) : $signed(mhi_x);
	assign om     = 50'sd268435456 - sm_kh;

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		mreq.start = 1'b0;
		mreq.a     = '0;
		mreq.b     = '0;
		dreq.start = 1'b0;
		dreq.num   = num_q;
		dreq.den   = den_sum[DivDW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					mreq.start = 1'b1;
					mreq.a     = {6'd0, mag32(x_q)};
					mreq.b     = {6'd0, amag};
					state_d    = ST_XP;
				end
			end
			ST_XP: begin
				if (mul_done) begin
					mreq.start = 1'b1;
					mreq.a     = {6'd0, p_q};
					mreq.b     = {6'd0, amag};
					state_d    = ST_T1;
				end
			end
			ST_T1: begin
				if (mul_done) begin
					mreq.start = 1'b1;
					mreq.a     = {6'd0, amag};
					mreq.b     = mhi[MulW-1:0];
					state_d    = ST_PP;
				end
			end
			ST_PP: begin
				if (mul_done) begin
					mreq.start = 1'b1;
					mreq.a     = {6'd0, pp_w};
					mreq.b     = {6'd0, hmag};
					state_d    = ST_D1;
				end
			end
			ST_D1: begin
				if (mul_done) begin
					mreq.start = 1'b1;
					mreq.a     = {6'd0, hmag};
					mreq.b     = mhi[MulW-1:0];
					state_d    = ST_DEN;
				end
			end
			ST_DEN: begin
				if (mul_done) begin
					dreq.start = 1'b1;
					mreq.start = 1'b1;
					mreq.a     = {6'd0, mag32(xp_q)};
					mreq.b     = {6'd0, hmag};
					state_d    = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					mreq.start = 1'b1;
					mreq.a     = {6'd0, mag32(k_w)};
					mreq.b     = innov_abs[MulW-1:0];
					state_d    = ST_KI;
				end
			end
			ST_KI: begin
				if (mul_done) begin
					mreq.start = 1'b1;
					mreq.a     = {6'd0, mag32(k_q)};
					mreq.b     = {6'd0, hmag};
					state_d    = ST_KH;
				end
			end
			ST_KH: begin
				if (mul_done) begin
					if (om <= 50'sd0) begin
						state_d = ST_DONE;
					end else begin
						mreq.start = 1'b1;
						mreq.a     = {6'd0, pp_q};
						mreq.b     = om[MulW-1:0];
						state_d    = ST_PN;
					end
				end
			end
			ST_PN: begin
				if (mul_done)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (load_out)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q  <= ResetTransition;
			h_q  <= ResetObservation;
			qn_q <= ResetProcNoise;
			rn_q <= ResetMeasNoise;
			x_q  <= 32'd0;
			p_q  <= ResetInitCov;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_TRANSITION:  a_q  <= cfg_data;
					CFG_OBSERVATION: h_q  <= cfg_data;
					CFG_PROC_NOISE:  qn_q <= cfg_data;
					CFG_MEAS_NOISE:  rn_q <= cfg_data;
					CFG_INIT_COV:    p_q  <= cfg_data;
					default: ;
				endcase
			end
			if (load_out) begin
				x_q <= xn_q;
				p_q <= pn_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working values of one item
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid)
			z_q <= measurement;
		if (state_q == ST_XP && mul_done)
			xp_q <= sat_s50((a_q[31] ^ x_q[31]) ? -$signed(mhi_x) : $signed(mhi_x));
		if (state_q == ST_PP && mul_done)
			pp_q <= pp_w;
		if (state_q == ST_D1 && mul_done)
			num_q <= mul_prod[63:0];
		if (state_q == ST_DEN && mul_done)
			den_zero_q <= (den_sum == 50'd0);
		if (state_q == ST_DIV && div_done) begin
			k_q         <= k_w;
			innov_neg_q <= innov[49];
		end
		if (state_q == ST_KI && mul_done)
			xn_q <= sat_s50(xn_sum);
		if (state_q == ST_KH && mul_done && om <= 50'sd0)
			pn_q <= 32'd0;
		if (state_q == ST_PN && mul_done)
			pn_q <= (mhi[47:32] != 16'd0) ? 32'hffff_ffff : mhi[31:0];
		if (load_out) begin
			est_q  <= xn_q;
			gain_q <= k_q;
			cov_q  <= pn_q;
		end
	end

	assign cfg_ready  = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign estimate   = est_q;
	assign gain       = gain_q;
	assign covariance = cov_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_init_cov_load: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == CFG_INIT_COV && state_q == ST_IDLE)
		|=> (p_q == $past(cfg_data)))
		else $error("initial covariance write did not load covariance");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && state_q != ST_DONE) |=> $stable(estimate))
		else $error("waiting result changed");
`endif

endmodule

`default_nettype wire

### rtl/skf_mul.sv
// ----------------------------------------------------------------------------
// skf_mul
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_mul
	import skf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mul_req_t          req,
	output logic                   done,
	output logic [2*MulW-1:0]      prod
);

	localparam int CntW = $clog2(MulW);

	logic [MulW-1:0]   a_q;
	logic [MulW-1:0]   b_q;
	logic [2*MulW-1:0] acc_q;
	logic [CntW-1:0]   cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [MulW:0]     sum;

	assign sum = {1'b0, acc_q[2*MulW-1:MulW]} + {1'b0, (b_q[0] ? a_q : {MulW{1'b0}})};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(MulW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[MulW-1:1]};
			b_q   <= {1'b0, b_q[MulW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

### rtl/skf_div.sv
// ----------------------------------------------------------------------------
// skf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_div
	import skf_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire div_req_t         req,
	output logic                  done,
	output logic [DivNW-1:0]      quo
);

	localparam int CntW = $clog2(DivNW);

	logic [DivNW-1:0] n_q;
	logic [DivDW-1:0] d_q;
	logic [DivDW-1:0] rem_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DivDW:0]   trial;
	logic [DivDW:0]   diff;
	logic             qbit;

	assign trial = {rem_q, n_q[DivNW-1]};
	assign diff  = trial - {1'b0, d_q};
	assign qbit  = (trial >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DivNW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= req.num;
			d_q   <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DivDW-1:0] : trial[DivDW-1:0];
			n_q   <= {n_q[DivNW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = n_q;

endmodule

`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the scalar kalman filter core. A behavioral predictor tracks
// estimate and covariance, every result is compared field by field against
// the oldest expected item. Directed extremes first, then random sequences
// under several coefficient settings, with random idling on both channels but in one no-idle run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
	import skf_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdlePct = 38;
	localparam int WatchLimit = 20000;

	typedef struct packed {
		logic [31:0] est;
		logic [31:0] k;
		logic [31:0] cov;
	} kf_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [31:0] measurement;
	logic out_valid;
	logic out_ready;
	logic [31:0] estimate;
	logic [31:0] gain;
	logic [31:0] covariance;
	logic cfg_valid;
	logic cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [31:0] cfg_data;

	logic [31:0] coef_a, coef_h, noise_q, noise_r, cov_init;
	logic [31:0] est_state, cov_state;
	kf_result_t expected_q[$];
	int n_errors = 0;
	int n_results = 0;
	int n_items = 0;
	int idle_cycles = 0;
	bit no_idle = 0;
	int watch = 0;

	scalar_kalman_filter_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .measurement(measurement),
		.out_valid(out_valid), .out_ready(out_ready),
		.estimate(estimate), .gain(gain), .covariance(covariance),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] umag(input logic signed [63:0] v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// floor(a*b / 2^28) at full precision
	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = a * b;
		return 64'(p >> 28);
	endfunction

	function automatic logic signed [63:0] sqmul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [63:0] m;
		m = qmul(umag(a), umag(b));
		return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [63:0] clamp_s32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [63:0] clamp_u32(input logic [63:0] v);
		return v > 64'hffff_ffff ? 64'hffff_ffff : v;
	endfunction

	function automatic kf_result_t filter_step(input logic [31:0] z_in);
		logic signed [63:0] a, h, z, x, xp, k, innov, xn, om;
		logic [63:0] amag, hmag, pp, den, q, pn;
		kf_result_t r;
		a = $signed(coef_a);
		h = $signed(coef_h);
		z = $signed(z_in);
		x = $signed(est_state);
		amag = umag(a);
		hmag = umag(h);
		xp = clamp_s32(sqmul(x, a));
		pp = clamp_u32(qmul(amag, qmul({32'd0, cov_state}, amag)) + noise_q);
		den = qmul(hmag, qmul(pp, hmag)) + noise_r;
		k = 0;
		if (den != 0) begin
			q = (pp * hmag) / den;
			if (h < 0)
				k = q > 64'd2147483648 ? -64'sd2147483648 : -$signed(q);
			else
				k = q > 64'd2147483647 ? 64'sd2147483647 : $signed(q);
		end
		innov = z - sqmul(xp, h);
		xn = clamp_s32(xp + sqmul(k, innov));
		om = 64'sd268435456 - sqmul(k, h);
		pn = om <= 0 ? 64'd0 : clamp_u32(qmul(pp, 64'(om)));
		est_state = xn[31:0];
		cov_state = pn[31:0];
		r.est = xn[31:0];
		r.k = k[31:0];
		r.cov = pn[31:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s at result %0d: got %h expected %h", what, n_results, got,
			want);
		n_errors++;
	endtask

	function automatic bit idle_now();
		return !no_idle && ($urandom_range(99) < IdlePct);
	endfunction

	task automatic send_measurement(input logic [31:0] z);
		while (idle_now()) @(posedge clk);
		in_valid <= 1'b1;
		measurement <= z;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q.push_back(filter_step(z));
		n_items++;
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_TRANSITION: coef_a = v;
			CFG_OBSERVATION: coef_h = v;
			CFG_PROC_NOISE: noise_q = v;
			CFG_MEAS_NOISE: noise_r = v;
			CFG_INIT_COV: begin
				cov_init = v;
				cov_state = v;
			end
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_filter(input logic [31:0] a, input logic [31:0] h,
			input logic [31:0] q, input logic [31:0] r, input logic [31:0] p);
		drain();
		write_register(CFG_TRANSITION, a);
		write_register(CFG_OBSERVATION, h);
		write_register(CFG_PROC_NOISE, q);
		write_register(CFG_MEAS_NOISE, r);
		write_register(CFG_INIT_COV, p);
	endtask

	function automatic logic [31:0] rand_near(input logic [31:0] center);
		return center + $urandom_range(65535) - 32768;
	endfunction

	task automatic test_directed();
		logic [31:0] vals[10];
		vals = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h0001_0000, 32'hffff_0000, 32'h5555_5555, 32'haaaa_aaaa, 32'h0};
		foreach (vals[i]) send_measurement(vals[i]);
	endtask

	task automatic test_corner_settings();
		// zero denominator: h and r zero
		set_filter(32'h1000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
		send_measurement(32'h0010_0000);
		send_measurement(32'h8000_0000);
		// saturating transition and covariance
		set_filter(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff);
		send_measurement(32'h7fff_ffff);
		send_measurement(32'h8000_0000);
		send_measurement(32'h1234_5678);
		// negative transition, large h driving 1 - k*h negative
		set_filter(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'h1000_0000);
		send_measurement(32'hffff_ffff);
		send_measurement(32'h0000_0001);
		set_filter(32'hf000_0000, 32'hf800_0000, 32'h1, 32'h0, 32'h0);
		send_measurement(32'h7fff_ffff);
		send_measurement(32'h8000_0001);
	endtask

	task automatic test_random_tracking(input int count);
		logic [31:0] center;
		center = $urandom();
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0)
				send_measurement($urandom());
			else
				send_measurement(rand_near(center));
		end
	endtask

	task automatic test_random_settings();
		for (int s = 0; s < 6; s++) begin
			set_filter($urandom(), $urandom(), $urandom_range(65535),
				$urandom(), $urandom());
			test_random_tracking(100);
		end
		for (int s = 0; s < 4; s++) begin
			set_filter(32'h1000_0000 + $urandom_range(4000000) - 2000000,
				32'h1000_0000 - $urandom_range(40000000), $urandom_range(9999),
				$urandom_range(9999999), $urandom_range(32'h2000_0000));
			test_random_tracking(150);
		end
	endtask

	task automatic test_no_idle();
		no_idle = 1;
		set_filter(ResetTransition, ResetObservation, ResetProcNoise, ResetMeasNoise,
			ResetInitCov);
		test_random_tracking(200);
		no_idle = 0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			out_ready <= !idle_now();
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected item", estimate, 32'h0);
				end else begin
					kf_result_t e;
					e = expected_q.pop_front();
					if (estimate !== e.est) report_mismatch("estimate", estimate, e.est);
					if (gain !== e.k) report_mismatch("gain", gain, e.k);
					if (covariance !== e.cov)
						report_mismatch("covariance", covariance, e.cov);
				end
				n_results++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				watch <= 0;
			else
				watch <= watch + 1;
			if (watch >= WatchLimit) begin
				$display("watchdog expired with %0d items pending", expected_q.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		measurement = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TRANSITION;
		cfg_data = '0;
		coef_a = ResetTransition;
		coef_h = ResetObservation;
		noise_q = ResetProcNoise;
		noise_r = ResetMeasNoise;
		cov_init = ResetInitCov;
		est_state = '0;
		cov_state = ResetInitCov;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_corner_settings();
		test_random_settings();
		test_no_idle();
		set_filter(ResetTransition, ResetObservation, ResetProcNoise, ResetMeasNoise,
			ResetInitCov);
		test_random_tracking(180);
		drain();
		repeat (400) @(posedge clk);
		$display("sent %0d measurements, checked %0d results", n_items, n_results);
		$display("covered extremes, zero denominator, saturation and 16 filter settings");
		if (n_errors == 0 && expected_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
